[rtl/core/matrix_to_quaternion_scale_top_assert.svh]
// Assertion macros shared by the matrix to quaternion RTL.
`ifndef MATRIX_TO_QUATERNION_SCALE_TOP_ASSERT_SVH
`define MATRIX_TO_QUATERNION_SCALE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MQS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MQS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mqs_pkg.sv]
// Types, constants and arithmetic steps for the matrix to quaternion pipeline.
package mqs_pkg;

  localparam int DATA_W       = 32;
  localparam int FRAC_W       = 16;
  localparam int SQ_IN_W      = 2 * DATA_W;
  localparam int ROOT_W       = DATA_W;
  localparam int SQ_REM_W     = ROOT_W + 2;
  localparam int RAD_W        = DATA_W + 3;
  localparam int NUM_W        = DATA_W + 1;
  localparam int S_W          = ROOT_W + 1;
  localparam int DREM_W       = S_W + 1;
  localparam int DIVN_W       = NUM_W + FRAC_W;
  localparam int SQRT_STAGES  = ROOT_W;
  localparam int DIV_STAGES   = DIVN_W;
  localparam int FRONT_STAGES = 4;
  localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 1;
  localparam int LANES        = 4;
  localparam int QLANE        = 3;
  localparam int NSLOT        = 3;

  localparam logic signed [RAD_W-1:0] QONE_RAD = RAD_W'(1) << FRAC_W;

  typedef struct packed {
    logic signed [DATA_W-1:0] m00;
    logic signed [DATA_W-1:0] m01;
    logic signed [DATA_W-1:0] m02;
    logic signed [DATA_W-1:0] m10;
    logic signed [DATA_W-1:0] m11;
    logic signed [DATA_W-1:0] m12;
    logic signed [DATA_W-1:0] m20;
    logic signed [DATA_W-1:0] m21;
    logic signed [DATA_W-1:0] m22;
  } mqs_in_t;

  typedef struct packed {
    logic        [DATA_W-1:0] scale_x;
    logic        [DATA_W-1:0] scale_y;
    logic        [DATA_W-1:0] scale_z;
    logic signed [DATA_W-1:0] quat_w;
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
  } mqs_out_t;

  // The branch code is also the position of the quarter term in (w, x, y, z).
  typedef enum logic [1:0] {BR_TRACE, BR_X, BR_Y, BR_Z} mqs_branch_t;

  typedef struct packed {
    logic [SQ_IN_W-1:0]  rad;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } mqs_sq_lane_t;

  typedef struct packed {
    mqs_branch_t                 branch;
    logic [NSLOT-1:0][NUM_W-1:0] nmag;
    logic [NSLOT-1:0]            nneg;
  } mqs_side_t;

  typedef struct packed {
    logic [DIVN_W-1:0] num;
    logic [DREM_W-1:0] rem;
    logic [DIVN_W-1:0] quo;
  } mqs_div_lane_t;

  typedef struct packed {
    mqs_branch_t                  branch;
    logic [NSLOT-1:0]             nneg;
    logic [S_W-1:0]               s;
    logic [NSLOT-1:0][DATA_W-1:0] scale;
  } mqs_dside_t;

  function automatic logic [DATA_W-1:0] mag_of(input logic signed [DATA_W-1:0] v);
    return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
  endfunction

  function automatic logic [NUM_W-1:0] num_mag(input logic signed [NUM_W-1:0] v);
    return v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
  endfunction

  // One digit of the restoring square root: two radicand bits in, one root bit out.
  function automatic mqs_sq_lane_t sqrt_step(input mqs_sq_lane_t l);
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    mqs_sq_lane_t        n;
    rem_sh = {l.rem[SQ_REM_W-3:0], l.rad[SQ_IN_W-1 -: 2]};
    trial  = {l.root, 2'b01};
    n.rad  = l.rad << 2;
    if (rem_sh >= trial) begin
      n.rem  = rem_sh - trial;
      n.root = {l.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = rem_sh;
      n.root = {l.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  // One bit of restoring long division.
  function automatic mqs_div_lane_t div_step(input mqs_div_lane_t l, input logic [S_W-1:0] s);
    logic [DREM_W-1:0] rem_sh;
    mqs_div_lane_t     n;
    rem_sh = {l.rem[S_W-1:0], l.num[DIVN_W-1]};
    n.num  = l.num << 1;
    if (rem_sh >= {1'b0, s}) begin
      n.rem = rem_sh - {1'b0, s};
      n.quo = {l.quo[DIVN_W-2:0], 1'b1};
    end else begin
      n.rem = rem_sh;
      n.quo = {l.quo[DIVN_W-2:0], 1'b0};
    end
    return n;
  endfunction

  function automatic logic [DATA_W-1:0] sat_q(input logic [DIVN_W-1:0] q, input logic neg);
    logic [DIVN_W-1:0] lim;
    logic [DIVN_W-1:0] m;
    lim = neg ? (DIVN_W'(1) << (DATA_W - 1)) : ((DIVN_W'(1) << (DATA_W - 1)) - 1'b1);
    m   = (q > lim) ? lim : q;
    return neg ? DATA_W'(-m) : DATA_W'(m);
  endfunction

endpackage

[rtl/core/matrix_to_quaternion_scale_top.sv]
// Matrix to quaternion and row scale: fully pipelined, one transform per cycle.
//
// A transform's 3x3 block is taken on in_item at a rising edge where start is
// high and busy is low. busy is set while rst_n is low and clears at the first
// edge with rst_n high, so from then on a new beat may be offered in every cycle.
// Each beat returns one result on out_item, marked by out_valid for exactly one
// cycle. Throughput is one beat per cycle. Each beat passes through the chain:
// input register, three front stages (magnitudes and sums, squares and branch
// select, row sums and radicand), 32 square-root digit stages and 49 quotient
// bit stages, one bit each, then the output register.
// The receiver cannot hold results off; none is needed, since nothing in the
// pipeline ever waits.
// Synchronous reset clears every valid bit, so beats in flight are dropped.
module matrix_to_quaternion_scale_top
  import mqs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  mqs_in_t  in_item,
  output logic     out_valid,
  output mqs_out_t out_item
);

  `include "matrix_to_quaternion_scale_top_assert.svh"

  logic busy_r;
  logic in_v_r;
  mqs_in_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      in_v_r <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      in_v_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      in_r <= in_item;
    end
  end

  assign busy = busy_r;

  // Front stage A: magnitudes, trace, radicands, off-diagonal sums and differences, diagonal compares.
  logic                    a_v_r;
  logic [DATA_W-1:0]       a_mag_r [9];
  logic signed [RAD_W-1:0] a_tr_r, a_rx_r, a_ry_r, a_rz_r;
  logic                    a_gt01_r, a_gt02_r, a_gt12_r;
  logic signed [NUM_W-1:0] a_dx_r, a_dy_r, a_dz_r, a_sxy_r, a_sxz_r, a_syz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_mag_r[0] <= mag_of(in_r.m00);
    a_mag_r[1] <= mag_of(in_r.m01);
    a_mag_r[2] <= mag_of(in_r.m02);
    a_mag_r[3] <= mag_of(in_r.m10);
    a_mag_r[4] <= mag_of(in_r.m11);
    a_mag_r[5] <= mag_of(in_r.m12);
    a_mag_r[6] <= mag_of(in_r.m20);
    a_mag_r[7] <= mag_of(in_r.m21);
    a_mag_r[8] <= mag_of(in_r.m22);
    a_tr_r <= RAD_W'(in_r.m00) + RAD_W'(in_r.m11) + RAD_W'(in_r.m22);
    a_rx_r <= QONE_RAD + RAD_W'(in_r.m00) - RAD_W'(in_r.m11) - RAD_W'(in_r.m22);
    a_ry_r <= QONE_RAD + RAD_W'(in_r.m11) - RAD_W'(in_r.m00) - RAD_W'(in_r.m22);
    a_rz_r <= QONE_RAD + RAD_W'(in_r.m22) - RAD_W'(in_r.m00) - RAD_W'(in_r.m11);
    a_gt01_r <= in_r.m00 > in_r.m11;
    a_gt02_r <= in_r.m00 > in_r.m22;
    a_gt12_r <= in_r.m11 > in_r.m22;
    a_dx_r  <= NUM_W'(in_r.m21) - NUM_W'(in_r.m12);
    a_dy_r  <= NUM_W'(in_r.m02) - NUM_W'(in_r.m20);
    a_dz_r  <= NUM_W'(in_r.m10) - NUM_W'(in_r.m01);
    a_sxy_r <= NUM_W'(in_r.m01) + NUM_W'(in_r.m10);
    a_sxz_r <= NUM_W'(in_r.m02) + NUM_W'(in_r.m20);
    a_syz_r <= NUM_W'(in_r.m12) + NUM_W'(in_r.m21);
  end

  // Front stage B: squares, branch choice, radicand and numerator selection.
  logic                    b_v_r;
  logic [SQ_IN_W-1:0]      b_sq_r [9];
  mqs_branch_t             b_br_r, b_br_nxt;
  logic signed [RAD_W-1:0] b_rad_r, b_rad_nxt;
  logic signed [NUM_W-1:0] b_num_r [NSLOT];
  logic signed [NUM_W-1:0] b_num_nxt [NSLOT];

  always_comb begin
    priority if (a_tr_r > 0) begin
      b_br_nxt = BR_TRACE;
    end else if (a_gt01_r && a_gt02_r) begin
      b_br_nxt = BR_X;
    end else if (a_gt12_r) begin
      b_br_nxt = BR_Y;
    end else begin
      b_br_nxt = BR_Z;
    end
  end

  // Numerators are listed in (w, x, y, z) order with the quarter term left out.
  always_comb begin
    unique case (b_br_nxt)
      BR_TRACE: begin
        b_rad_nxt    = a_tr_r + QONE_RAD;
        b_num_nxt[0] = a_dx_r;
        b_num_nxt[1] = a_dy_r;
        b_num_nxt[2] = a_dz_r;
      end
      BR_X: begin
        b_rad_nxt    = a_rx_r;
        b_num_nxt[0] = a_dx_r;
        b_num_nxt[1] = a_sxy_r;
        b_num_nxt[2] = a_sxz_r;
      end
      BR_Y: begin
        b_rad_nxt    = a_ry_r;
        b_num_nxt[0] = a_dy_r;
        b_num_nxt[1] = a_sxy_r;
        b_num_nxt[2] = a_syz_r;
      end
      default: begin
        b_rad_nxt    = a_rz_r;
        b_num_nxt[0] = a_dz_r;
        b_num_nxt[1] = a_sxz_r;
        b_num_nxt[2] = a_syz_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      b_sq_r[i] <= SQ_IN_W'(a_mag_r[i]) * SQ_IN_W'(a_mag_r[i]);
    end
    b_br_r  <= b_br_nxt;
    b_rad_r <= b_rad_nxt;
    for (int i = 0; i < NSLOT; i++) begin
      b_num_r[i] <= b_num_nxt[i];
    end
  end

  // Front stage C: row sums, shifted radicand, numerator sign and magnitude.
  logic               c_v_r;
  logic [SQ_IN_W-1:0] c_sum_r [NSLOT];
  logic [SQ_IN_W-1:0] c_qrad_r;
  mqs_side_t          c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NSLOT; i++) begin
      c_sum_r[i] <= b_sq_r[3*i] + b_sq_r[3*i+1] + b_sq_r[3*i+2];
      c_side_r.nmag[i] <= num_mag(b_num_r[i]);
      c_side_r.nneg[i] <= b_num_r[i][NUM_W-1];
    end
    c_qrad_r <= (b_rad_r > 0) ? (SQ_IN_W'($unsigned(b_rad_r)) << FRAC_W) : '0;
    c_side_r.branch <= b_br_r;
  end

  // Square-root pipeline: lanes 0 to 2 are the row lengths, lane 3 the quaternion root.
  mqs_sq_lane_t sq_src [SQRT_STAGES][LANES];
  mqs_sq_lane_t sq_r   [SQRT_STAGES][LANES];
  logic         sq_v_src [SQRT_STAGES];
  logic         sq_v_r   [SQRT_STAGES];
  mqs_side_t    sq_side_src [SQRT_STAGES];
  mqs_side_t    sq_side_r   [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      assign sq_v_src[k]    = c_v_r;
      assign sq_side_src[k] = c_side_r;
    end else begin : g_next
      assign sq_v_src[k]    = sq_v_r[k-1];
      assign sq_side_src[k] = sq_side_r[k-1];
    end
    for (genvar j = 0; j < LANES; j++) begin : g_lane
      if (k == 0 && j == QLANE) begin : g_qsrc
        assign sq_src[k][j] = '{rad: c_qrad_r, rem: '0, root: '0};
      end else if (k == 0) begin : g_rsrc
        assign sq_src[k][j] = '{rad: c_sum_r[j], rem: '0, root: '0};
      end else begin : g_psrc
        assign sq_src[k][j] = sq_r[k-1][j];
      end
      always_ff @(posedge clk) begin
        sq_r[k][j] <= sqrt_step(sq_src[k][j]);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else begin
        sq_v_r[k] <= sq_v_src[k];
      end
    end
    always_ff @(posedge clk) begin
      sq_side_r[k] <= sq_side_src[k];
    end
  end

  // Division pipeline: three quotients by the shared S, one bit per stage.
  mqs_div_lane_t dv_src [DIV_STAGES][NSLOT];
  mqs_div_lane_t dv_r   [DIV_STAGES][NSLOT];
  logic          dv_v_src [DIV_STAGES];
  logic          dv_v_r   [DIV_STAGES];
  mqs_dside_t    dv_side_src [DIV_STAGES];
  mqs_dside_t    dv_side_r   [DIV_STAGES];
  mqs_dside_t    dv_init;

  always_comb begin
    dv_init.branch = sq_side_r[SQRT_STAGES-1].branch;
    dv_init.nneg   = sq_side_r[SQRT_STAGES-1].nneg;
    dv_init.s      = {sq_r[SQRT_STAGES-1][QLANE].root, 1'b0};
    for (int i = 0; i < NSLOT; i++) begin
      dv_init.scale[i] = sq_r[SQRT_STAGES-1][i].root;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    if (k == 0) begin : g_first
      assign dv_v_src[k]    = sq_v_r[SQRT_STAGES-1];
      assign dv_side_src[k] = dv_init;
    end else begin : g_next
      assign dv_v_src[k]    = dv_v_r[k-1];
      assign dv_side_src[k] = dv_side_r[k-1];
    end
    for (genvar j = 0; j < NSLOT; j++) begin : g_lane
      if (k == 0) begin : g_isrc
        assign dv_src[k][j] = '{num: {sq_side_r[SQRT_STAGES-1].nmag[j], FRAC_W'(0)},
                                rem: '0, quo: '0};
      end else begin : g_psrc
        assign dv_src[k][j] = dv_r[k-1][j];
      end
      always_ff @(posedge clk) begin
        dv_r[k][j] <= div_step(dv_src[k][j], dv_side_src[k].s);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else begin
        dv_v_r[k] <= dv_v_src[k];
      end
    end
    always_ff @(posedge clk) begin
      dv_side_r[k] <= dv_side_src[k];
    end
  end

  // Output stage: saturate, place the quarter term, zero the quaternion when S is zero.
  mqs_dside_t        fin_side;
  logic [DATA_W-1:0] fin_q [NSLOT];
  logic [DATA_W-1:0] fin_quarter;
  logic              fin_s_zero;
  mqs_out_t          out_nxt;
  mqs_out_t          out_r;
  logic              out_valid_r;

  assign fin_side    = dv_side_r[DIV_STAGES-1];
  assign fin_quarter = DATA_W'(fin_side.s >> 2);
  assign fin_s_zero  = (fin_side.s == '0);

  always_comb begin
    for (int i = 0; i < NSLOT; i++) begin
      fin_q[i] = sat_q(dv_r[DIV_STAGES-1][i].quo, fin_side.nneg[i]);
    end
  end

  always_comb begin
    out_nxt.scale_x = fin_side.scale[0];
    out_nxt.scale_y = fin_side.scale[1];
    out_nxt.scale_z = fin_side.scale[2];
    unique case (fin_side.branch)
      BR_TRACE: begin
        out_nxt.quat_w = fin_quarter;
        out_nxt.quat_x = fin_q[0];
        out_nxt.quat_y = fin_q[1];
        out_nxt.quat_z = fin_q[2];
      end
      BR_X: begin
        out_nxt.quat_w = fin_q[0];
        out_nxt.quat_x = fin_quarter;
        out_nxt.quat_y = fin_q[1];
        out_nxt.quat_z = fin_q[2];
      end
      BR_Y: begin
        out_nxt.quat_w = fin_q[0];
        out_nxt.quat_x = fin_q[1];
        out_nxt.quat_y = fin_quarter;
        out_nxt.quat_z = fin_q[2];
      end
      default: begin
        out_nxt.quat_w = fin_q[0];
        out_nxt.quat_x = fin_q[1];
        out_nxt.quat_y = fin_q[2];
        out_nxt.quat_z = fin_quarter;
      end
    endcase
    if (fin_s_zero) begin
      out_nxt.quat_w = '0;
      out_nxt.quat_x = '0;
      out_nxt.quat_y = '0;
      out_nxt.quat_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `MQS_ASSERT_IMP(a_out_matches_accept, out_valid, $past(start && !busy, LATENCY),
                  "result beat without a matching input beat")
  `MQS_ASSERT_IMP(a_sqrt_rem_bound, sq_v_r[SQRT_STAGES-1],
                  (sq_r[SQRT_STAGES-1][QLANE].rem <= {sq_r[SQRT_STAGES-1][QLANE].root, 1'b0})
                  && (sq_r[SQRT_STAGES-1][0].rem <= {sq_r[SQRT_STAGES-1][0].root, 1'b0}),
                  "square root remainder out of range")
  `MQS_ASSERT_NXT(a_zero_s_clears, dv_v_r[DIV_STAGES-1] && fin_s_zero,
                  (out_item.quat_w == '0) && (out_item.quat_x == '0)
                  && (out_item.quat_y == '0) && (out_item.quat_z == '0),
                  "zero S did not clear the quaternion")

endmodule
